### hdl/ght_pkg.sv
package ght_pkg;

    // command codes on the input channel
    localparam logic [1:0] CMD_ALLOC  = 2'd0;
    localparam logic [1:0] CMD_FREE   = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // classified operation
    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_LOOKUP,
        OP_BAD
    } t_op;

    // command as it waits between front and back
    typedef struct packed {
        t_op         op;
        logic        idx_wide;
        logic [31:0] slot_index;
        logic [31:0] generation;
        logic [31:0] payload;
        logic [1:0]  fmt;
    } t_item;

endpackage

### hdl/ght_if.sv
interface ght_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] slot_index;
    logic [31:0] handle_generation;
    logic [31:0] payload_in;
    logic [1:0]  format_in;

    modport source (
        output valid, cmd, slot_index, handle_generation, payload_in, format_in,
        input  ready
    );
    modport sink (
        input  valid, cmd, slot_index, handle_generation, payload_in, format_in,
        output ready
    );
endinterface

interface ght_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  out_index;
    logic [31:0] out_generation;
    logic [31:0] payload_out;
    logic [1:0]  format_out;

    modport source (
        output valid, status, out_index, out_generation, payload_out, format_out,
        input  ready
    );
    modport sink (
        input  valid, status, out_index, out_generation, payload_out, format_out,
        output ready
    );
endinterface

### hdl/generational_handle_table.sv
// the back reads the slot (S_READ), then checks and writes it (S_EXEC); its result
// is registered; it takes no new command until the last commits to a free output
// the front queue holds two commands, so input transfers continue while the back works
// reset: synchronous, active low; clears counters, not live marks or generations,
// as slots from the used count up read as unallocated; no clearing pass is needed
module generational_handle_table #(
    parameter int SLOTS = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ght_cmd_if.sink    i_cmd,
    ght_rsp_if.source  o_rsp
);
    import ght_pkg::*;

    logic  w_item_valid;
    logic  w_item_ready;
    t_item w_item;

    // accept and classify commands
    ght_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_item_ready (w_item_ready)
    );

    // slot table, free stack and result register
    ght_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_item_ready (w_item_ready),
        .o_rsp        (o_rsp)
    );

endmodule

### hdl/ght_front.sv
module ght_front #(
    parameter int SLOTS = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ght_cmd_if.sink        i_cmd,
    output logic           o_item_valid,
    output ght_pkg::t_item o_item,
    input  logic           i_item_ready
);
    import ght_pkg::*;

    t_item       r_q [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    t_item       w_item;
    logic        w_push;
    logic        w_pop;

    // classify the incoming command
    always_comb begin
        w_item.idx_wide   = i_cmd.slot_index >= 32'(SLOTS);
        w_item.slot_index = i_cmd.slot_index;
        w_item.generation = i_cmd.handle_generation;
        w_item.payload    = i_cmd.payload_in;
        w_item.fmt        = i_cmd.format_in;
        case (i_cmd.cmd)
            CMD_ALLOC:  w_item.op = OP_ALLOC;
            CMD_FREE:   w_item.op = OP_FREE;
            CMD_LOOKUP: w_item.op = OP_LOOKUP;
            default:    w_item.op = OP_BAD;
        endcase
    end

    // two-entry queue toward the back end
    assign i_cmd.ready  = r_count != 2'd2;
    assign w_push       = i_cmd.valid && i_cmd.ready;
    assign o_item_valid = r_count != 2'd0;
    assign o_item       = r_q[r_rd_ptr];
    assign w_pop        = o_item_valid && i_item_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### hdl/ght_back.sv
module ght_back #(
    parameter int SLOTS = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_item_valid,
    input  ght_pkg::t_item i_item,
    output logic           o_item_ready,
    ght_rsp_if.source      o_rsp
);
    import ght_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    typedef struct packed {
        logic [31:0] gen;
        logic        live;
        logic [31:0] payload;
        logic [1:0]  fmt;
    } t_slot;

    typedef enum logic {
        S_READ,
        S_EXEC
    } t_state;

    // slot table and free stack
    t_slot       r_slot_mem [SLOTS];
    logic [IW-1:0] r_stack  [SLOTS];

    t_state        r_state;
    logic [CW-1:0] r_free_count;
    logic [CW-1:0] r_used_count;
    logic [IW-1:0] r_top;
    t_item         r_cur;
    logic [IW-1:0] r_addr;
    logic          r_pop;
    logic          r_full;
    logic          r_in_range;
    t_slot         r_rd_slot;
    logic [IW-1:0] r_rd_stack;

    logic          r_out_valid;
    logic [1:0]    r_status;
    logic [7:0]    r_out_index;
    logic [31:0]   r_out_gen;
    logic [31:0]   r_payload_out;
    logic [1:0]    r_format_out;

    logic          w_take;
    logic [IW-1:0] w_idx_lo;
    logic          w_pop;
    logic          w_full;
    logic [IW-1:0] w_rd_addr;
    logic          w_in_range;
    logic [IW-1:0] w_stk_rd_addr;
    logic          w_out_free;
    logic          w_commit;
    logic [31:0]   w_new_gen;
    logic          w_handle_ok;
    logic          w_slot_we;
    t_slot         w_slot_wdata;
    logic          w_stk_we;

    logic [1:0]    n_status;
    logic [7:0]    n_out_index;
    logic [31:0]   n_out_gen;
    logic [31:0]   n_payload_out;
    logic [1:0]    n_format_out;
    logic [CW-1:0] n_free_count;
    logic [CW-1:0] n_used_count;
    logic [IW-1:0] n_top;

    // read phase: pick the slot to touch
    assign o_item_ready  = r_state == S_READ;
    assign w_take        = (r_state == S_READ) && i_item_valid;
    assign w_idx_lo      = i_item.slot_index[IW-1:0];
    assign w_pop         = r_free_count != '0;
    assign w_full        = !w_pop && (r_used_count == CW'(SLOTS));
    assign w_rd_addr     = (i_item.op == OP_ALLOC) ?
                           (w_pop ? r_top : r_used_count[IW-1:0]) : w_idx_lo;
    assign w_in_range    = !i_item.idx_wide && (CW'(w_idx_lo) < r_used_count);
    assign w_stk_rd_addr = IW'(r_free_count - CW'(2));

    // execute phase: check the handle and update the slot
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_commit    = (r_state == S_EXEC) && w_out_free;
    assign w_new_gen   = (r_pop ? r_rd_slot.gen : 32'd0) + 32'd1;
    assign w_handle_ok = r_in_range && r_rd_slot.live &&
                         (r_rd_slot.gen == r_cur.generation);

    always_comb begin
        n_status      = ST_INVALID;
        n_out_index   = 8'd0;
        n_out_gen     = 32'd0;
        n_payload_out = 32'd0;
        n_format_out  = 2'd0;
        n_free_count  = r_free_count;
        n_used_count  = r_used_count;
        n_top         = r_top;
        w_slot_we     = 1'b0;
        w_slot_wdata  = r_rd_slot;
        w_stk_we      = 1'b0;
        case (r_cur.op)
            OP_ALLOC: begin
                if (r_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status             = ST_OK;
                    w_slot_we            = 1'b1;
                    w_slot_wdata.gen     = w_new_gen;
                    w_slot_wdata.live    = 1'b1;
                    w_slot_wdata.payload = r_cur.payload;
                    w_slot_wdata.fmt     = r_cur.fmt;
                    n_out_index          = 8'(r_addr);
                    n_out_gen            = w_new_gen;
                    if (r_pop) begin
                        n_free_count = r_free_count - CW'(1);
                        n_top        = r_rd_stack;
                    end else begin
                        n_used_count = r_used_count + CW'(1);
                    end
                end
            end
            OP_FREE: begin
                if (w_handle_ok && (r_free_count < CW'(SLOTS))) begin
                    n_status          = ST_OK;
                    w_slot_we         = 1'b1;
                    w_slot_wdata.live = 1'b0;
                    w_stk_we          = 1'b1;
                    n_free_count      = r_free_count + CW'(1);
                    n_top             = r_addr;
                end
            end
            OP_LOOKUP: begin
                if (w_handle_ok) begin
                    n_status      = ST_OK;
                    n_payload_out = r_rd_slot.payload;
                    n_format_out  = r_rd_slot.fmt;
                end
            end
            default: begin
                n_status = ST_INVALID;
            end
        endcase
    end

    // slot table port
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_rd_slot <= r_slot_mem[w_rd_addr];
        end
        if (w_commit && w_slot_we) begin
            r_slot_mem[r_addr] <= w_slot_wdata;
        end
    end

    // free stack port, prefetching the entry under the cached top
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_rd_stack <= r_stack[w_stk_rd_addr];
        end
        if (w_commit && w_stk_we) begin
            r_stack[r_free_count[IW-1:0]] <= r_addr;
        end
    end

    // sequencer, counters and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_READ;
            r_free_count <= '0;
            r_used_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_READ: begin
                    if (i_item_valid) begin
                        r_cur      <= i_item;
                        r_addr     <= w_rd_addr;
                        r_pop      <= w_pop && (i_item.op == OP_ALLOC);
                        r_full     <= w_full;
                        r_in_range <= w_in_range;
                        r_state    <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_commit) begin
                        r_free_count  <= n_free_count;
                        r_used_count  <= n_used_count;
                        r_top         <= n_top;
                        r_status      <= n_status;
                        r_out_index   <= n_out_index;
                        r_out_gen     <= n_out_gen;
                        r_payload_out <= n_payload_out;
                        r_format_out  <= n_format_out;
                        r_state       <= S_READ;
                    end
                end
                default: begin
                    r_state <= S_READ;
                end
            endcase
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_status;
    assign o_rsp.out_index      = r_out_index;
    assign o_rsp.out_generation = r_out_gen;
    assign o_rsp.payload_out    = r_payload_out;
    assign o_rsp.format_out     = r_format_out;

    // free slots are a subset of the slots handed out
    a_count_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_count <= r_used_count)
        else $error("free count exceeds used count");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used_count <= CW'(SLOTS))
        else $error("used count beyond table size");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> r_out_valid)
        else $error("committed command left no result");

    a_full_exhausted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_cur.op == OP_ALLOC && r_full) |->
        (r_free_count == '0 && r_used_count == CW'(SLOTS)))
        else $error("full reported with slots available");

endmodule
